// ----- rtl/core/multitap_text_entry_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the multitap text entry block
// Shared property forms, clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef MULTITAP_TEXT_ENTRY_MACROS_SVH
`define MULTITAP_TEXT_ENTRY_MACROS_SVH

// Same-cycle implication.
`define MTE_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MTE_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/mte_pkg.sv -----
// ---------------------------------------------------------------------------
// mte_pkg
// Types, codes and the character ROM of the multitap text entry block.
// ---------------------------------------------------------------------------
package mte_pkg;

  localparam int KEY_ROWS   = 10;
  localparam int ROW_SLOTS  = 9;
  localparam int LAST_SLOT  = 8;
  localparam int MAX_EVENTS = 4;

  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [3:0]  NO_KEY        = 4'hF;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_BS    = 2'd2,
    KIND_LEFT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [6:0] code;
    logic       last;
  } event_t;

  // One row per key (keys 1..9 then 0); a zero marks an empty slot.
  localparam logic [6:0] GLYPH_ROM [KEY_ROWS][ROW_SLOTS] = '{
    '{7'h2E, 7'h2D, 7'h40, 7'h31, 7'h2F, 7'h00, 7'h00, 7'h00, 7'h00},
    '{7'h61, 7'h62, 7'h63, 7'h32, 7'h41, 7'h42, 7'h43, 7'h00, 7'h00},
    '{7'h64, 7'h65, 7'h66, 7'h33, 7'h44, 7'h45, 7'h46, 7'h00, 7'h00},
    '{7'h67, 7'h68, 7'h69, 7'h34, 7'h47, 7'h48, 7'h49, 7'h00, 7'h00},
    '{7'h6A, 7'h6B, 7'h6C, 7'h35, 7'h4A, 7'h4B, 7'h4C, 7'h00, 7'h00},
    '{7'h6D, 7'h6E, 7'h6F, 7'h36, 7'h4D, 7'h4E, 7'h4F, 7'h00, 7'h00},
    '{7'h70, 7'h71, 7'h72, 7'h73, 7'h37, 7'h50, 7'h51, 7'h52, 7'h53},
    '{7'h74, 7'h75, 7'h76, 7'h38, 7'h54, 7'h55, 7'h56, 7'h00, 7'h00},
    '{7'h77, 7'h78, 7'h79, 7'h7A, 7'h39, 7'h57, 7'h58, 7'h59, 7'h5A},
    '{7'h23, 7'h2A, 7'h30, 7'h3F, 7'h21, 7'h3A, 7'h3B, 7'h2C, 7'h00}
  };

endpackage

// ----- rtl/core/mte_in_if.sv -----
// ---------------------------------------------------------------------------
// mte_in_if
// Input channel: one key press or timer tick per word.
// ---------------------------------------------------------------------------
interface mte_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [3:0] key_row;

  modport source (output valid, output op, output key_row, input ready);
  modport sink   (input valid, input op, input key_row, output ready);
endinterface

// ----- rtl/core/mte_out_if.sv -----
// ---------------------------------------------------------------------------
// mte_out_if
// Result channel: one edit event per word.
// ---------------------------------------------------------------------------
interface mte_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [6:0] char_code;
  logic       last;

  modport source (output valid, output event_kind, output char_code, output last,
                  input ready);
  modport sink   (input valid, input event_kind, input char_code, input last,
                  output ready);
endinterface

// ----- rtl/core/multitap_text_entry.sv -----
// ---------------------------------------------------------------------------
// multitap_text_entry
// Multitap keypad text entry: key presses and ticks become edit events.
// ---------------------------------------------------------------------------
// Flow: an accepted word is held in the input register until the event buffer
// is free, then its events are built in one pass and loaded into the buffer,
// from which the first event is offered.
// Throughput: while the output is ready, events leave one per cycle from a
// four-entry event buffer; a valid key press yields 2 to 4 events, a committing
// tick 1 and a silent tick none; the next word waits in the input register meanwhile.
// Reset: synchronous, active low; timeout returns to 1000 ticks, no key held.
`include "multitap_text_entry_macros.svh"

module multitap_text_entry (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_wdata,
  mte_in_if.sink        in_ch,
  mte_out_if.source     out_ch
);

  // Configuration and block state.
  logic [15:0] timeout_r;
  logic [3:0]  prev_key_r,  prev_key_nxt;
  logic [3:0]  pos_r,       pos_nxt;
  logic        pending_r,   pending_nxt;
  logic [15:0] countdown_r, countdown_nxt;

  // Input register.
  logic        s1_valid_r;
  logic        s1_op_r;
  logic [3:0]  s1_row_r;

  // Event buffer.
  mte_pkg::event_t slot_r [mte_pkg::MAX_EVENTS];
  mte_pkg::event_t slot_nxt [mte_pkg::MAX_EVENTS];
  logic [2:0]  rem_r, n_nxt;
  logic [1:0]  rd_idx_r;

  logic        buf_free;
  logic        s1_adv;
  logic        out_take;

  // Event building.
  logic        row_ok;
  logic [3:0]  safe_row;
  logic        same_key;
  logic [3:0]  pos_inc;
  logic [3:0]  pos_try;
  logic [6:0]  glyph_try;
  logic [6:0]  glyph;

  assign out_take = out_ch.valid && out_ch.ready;
  assign buf_free = (rem_r == 3'd0) || ((rem_r == 3'd1) && out_ch.ready);
  assign s1_adv   = s1_valid_r && buf_free;
  assign in_ch.ready = !s1_valid_r || s1_adv;

  assign row_ok   = s1_row_r < 4'(mte_pkg::KEY_ROWS);
  assign safe_row = row_ok ? s1_row_r : 4'd0;
  assign same_key = pending_r && (s1_row_r == prev_key_r);
  assign pos_inc  = (pos_r >= 4'(mte_pkg::LAST_SLOT)) ? 4'd0 : pos_r + 4'd1;
  assign pos_try  = same_key ? pos_inc : 4'd0;
  assign glyph_try = mte_pkg::GLYPH_ROM[safe_row][pos_try];
  assign glyph    = (glyph_try == 7'd0) ? mte_pkg::GLYPH_ROM[safe_row][0] : glyph_try;

  always_comb begin
    prev_key_nxt  = prev_key_r;
    pos_nxt       = pos_r;
    pending_nxt   = pending_r;
    countdown_nxt = countdown_r;
    n_nxt         = 3'd0;
    for (int i = 0; i < mte_pkg::MAX_EVENTS; i++) begin
      slot_nxt[i] = '{kind: mte_pkg::KIND_LEFT, code: 7'd0, last: 1'b1};
    end

    if (s1_op_r == mte_pkg::OP_TICK) begin
      if (pending_r) begin
        if (countdown_r <= 16'd1) begin
          pending_nxt   = 1'b0;
          countdown_nxt = 16'd0;
          slot_nxt[0]   = '{kind: mte_pkg::KIND_RIGHT, code: 7'd0, last: 1'b1};
          n_nxt         = 3'd1;
        end else begin
          countdown_nxt = countdown_r - 16'd1;
        end
      end
    end else if (row_ok) begin
      prev_key_nxt  = s1_row_r;
      pos_nxt       = (glyph_try == 7'd0) ? 4'd0 : pos_try;
      pending_nxt   = 1'b1;
      countdown_nxt = timeout_r;
      if (same_key) begin
        slot_nxt[0] = '{kind: mte_pkg::KIND_RIGHT, code: 7'd0,  last: 1'b0};
        slot_nxt[1] = '{kind: mte_pkg::KIND_BS,    code: 7'd0,  last: 1'b0};
        slot_nxt[2] = '{kind: mte_pkg::KIND_CHAR,  code: glyph, last: 1'b0};
        n_nxt       = 3'd4;
      end else if (pending_r) begin
        slot_nxt[0] = '{kind: mte_pkg::KIND_RIGHT, code: 7'd0,  last: 1'b0};
        slot_nxt[1] = '{kind: mte_pkg::KIND_CHAR,  code: glyph, last: 1'b0};
        n_nxt       = 3'd3;
      end else begin
        slot_nxt[0] = '{kind: mte_pkg::KIND_CHAR,  code: glyph, last: 1'b0};
        n_nxt       = 3'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= mte_pkg::TIMEOUT_RESET;
      prev_key_r  <= mte_pkg::NO_KEY;
      pos_r       <= 4'd0;
      pending_r   <= 1'b0;
      countdown_r <= 16'd0;
      s1_valid_r  <= 1'b0;
      rem_r       <= 3'd0;
      rd_idx_r    <= 2'd0;
    end else begin
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (s1_adv) begin
        prev_key_r  <= prev_key_nxt;
        pos_r       <= pos_nxt;
        pending_r   <= pending_nxt;
        countdown_r <= countdown_nxt;
        rem_r       <= n_nxt;
        rd_idx_r    <= 2'd0;
      end else if (out_take) begin
        rem_r    <= rem_r - 3'd1;
        rd_idx_r <= rd_idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_op_r  <= in_ch.op;
      s1_row_r <= in_ch.key_row;
    end
    if (s1_adv) begin
      for (int i = 0; i < mte_pkg::MAX_EVENTS; i++) begin
        slot_r[i] <= slot_nxt[i];
      end
    end
  end

  assign out_ch.valid      = rem_r != 3'd0;
  assign out_ch.event_kind = slot_r[rd_idx_r].kind;
  assign out_ch.char_code  = slot_r[rd_idx_r].code;
  assign out_ch.last       = slot_r[rd_idx_r].last;

  // The word marked last is exactly the final one left in the buffer.
  `MTE_ASSERT_NOW(a_last_marks_end, out_ch.valid, out_ch.last == (rem_r == 3'd1), "bad last flag")
  // Without a pending timeout the countdown rests at zero.
  `MTE_ASSERT_NOW(a_idle_countdown, !pending_r, countdown_r == 16'd0, "countdown while idle")
  // Events built from a word are offered on the next cycle.
  `MTE_ASSERT_NEXT(a_events_follow, s1_adv && (n_nxt != 3'd0), out_ch.valid, "events not offered")
  // An empty input register always takes a word.
  `MTE_ASSERT_NOW(a_ready_when_empty, !s1_valid_r, in_ch.ready, "input stalled while empty")
  // The buffer never holds more than four events.
  `MTE_ASSERT_NOW(a_rem_bound, 1'b1, rem_r <= 3'(mte_pkg::MAX_EVENTS), "event count overflow")

endmodule
